// ----- rtl/jbt_pkg.sv -----
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, character codes and keyword helpers for the byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

   typedef enum logic [3:0] {
      KIND_LBRACE      = 4'd0,
      KIND_RBRACE      = 4'd1,
      KIND_LBRACKET    = 4'd2,
      KIND_RBRACKET    = 4'd3,
      KIND_COLON       = 4'd4,
      KIND_COMMA       = 4'd5,
      KIND_STRING      = 4'd6,
      KIND_NUMBER      = 4'd7,
      KIND_TRUE        = 4'd8,
      KIND_FALSE       = 4'd9,
      KIND_NULL        = 4'd10,
      KIND_TEXT        = 4'd11,
      KIND_BAD_WORD    = 4'd12,
      KIND_OPEN_STRING = 4'd13
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'b001,
      MODE_STRING = 3'b010,
      MODE_WORD   = 3'b100
   } mode_type;

   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_COMMA    = 8'h2C;
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;

   // numeric flag bits
   localparam int NUM_VALID = 0;
   localparam int NUM_DOT   = 1;
   localparam int NUM_DIGIT = 2;

   // keyword match bits
   localparam int KW_TRUE  = 0;
   localparam int KW_FALSE = 1;
   localparam int KW_NULL  = 2;

   localparam logic [2:0] LEN_MAX = 3'd7;

   typedef struct packed {
      logic [2:0] length;
      logic [2:0] keyword_match;
      logic [2:0] numeric_flags;
   } word_state_type;

   localparam word_state_type WORD_CLEAR = '{length: 3'd0, keyword_match: 3'b111,
                                             numeric_flags: 3'b001};

   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     char_value;
      logic           run_end;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]          count;
      rsp_item_type [1:0]  items;
   } scan_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // expected character of {null, false, true} at a word position, zero past the end
   function automatic logic [23:0] keyword_chars(input logic [2:0] pos);
      logic [23:0] r;
      unique case (pos)
         3'd0:    r = {8'("n"), 8'("f"), 8'("t")};
         3'd1:    r = {8'("u"), 8'("a"), 8'("r")};
         3'd2:    r = {8'("l"), 8'("l"), 8'("u")};
         3'd3:    r = {8'("l"), 8'("s"), 8'("e")};
         3'd4:    r = {8'h00, 8'("e"), 8'h00};
         default: r = 24'h0;
      endcase
      return r;
   endfunction

   function automatic word_state_type word_add(input word_state_type s, input logic [7:0] c);
      word_state_type r;
      logic [7:0]     lc;
      logic [23:0]    kc;
      r  = s;
      lc = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
      kc = keyword_chars(s.length);
      // words hold no zero byte, so a zero expected char never matches
      if (kc[7:0] != lc)   r.keyword_match[KW_TRUE]  = 1'b0;
      if (kc[15:8] != lc)  r.keyword_match[KW_FALSE] = 1'b0;
      if (kc[23:16] != lc) r.keyword_match[KW_NULL]  = 1'b0;
      if (c == CHAR_DOT) begin
         if (s.numeric_flags[NUM_DOT]) r.numeric_flags[NUM_VALID] = 1'b0;
         r.numeric_flags[NUM_DOT] = 1'b1;
      end else if (is_digit(c)) begin
         r.numeric_flags[NUM_DIGIT] = 1'b1;
      end else begin
         r.numeric_flags[NUM_VALID] = 1'b0;
      end
      if (s.length != LEN_MAX) r.length = s.length + 3'd1;
      return r;
   endfunction

   function automatic token_kind_type word_kind(input word_state_type s);
      token_kind_type k;
      priority if (s.numeric_flags[NUM_VALID] && s.numeric_flags[NUM_DIGIT]) begin
         k = KIND_NUMBER;
      end else if (s.keyword_match[KW_TRUE] && (s.length == 3'd4)) begin
         k = KIND_TRUE;
      end else if (s.keyword_match[KW_FALSE] && (s.length == 3'd5)) begin
         k = KIND_FALSE;
      end else if (s.keyword_match[KW_NULL] && (s.length == 3'd4)) begin
         k = KIND_NULL;
      end else begin
         k = KIND_BAD_WORD;
      end
      return k;
   endfunction

endpackage

// ----- rtl/jbt_channels.sv -----
// ----------------------------------------------------------------------------
// jbt channels
// Request and response handshake channels of the byte tokenizer.
// ----------------------------------------------------------------------------
interface jbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jbt_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [7:0] char_value;
   logic       run_end;

   modport source (output valid, output token_kind, output char_value, output run_end,
                   input ready);
   modport sink   (input valid, input token_kind, input char_value, input run_end,
                   output ready);
endinterface

// ----- rtl/jbt_scan.sv -----
// ----------------------------------------------------------------------------
// jbt_scan
// Scan state and per-byte token logic: turns one held byte into up to two
// results and updates the mode and word classification flags.
// ----------------------------------------------------------------------------
module jbt_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           text_byte,
   input  logic                 end_of_text,
   output jbt_pkg::scan_out_type result
);

   jbt_pkg::mode_type       mode_ff, mode_in;
   jbt_pkg::word_state_type word_ff, word_in;
   jbt_pkg::word_state_type added;

   logic                    main_emit, idle_emit, eot_emit;
   jbt_pkg::token_kind_type main_kind, idle_kind, eot_kind;
   logic                    do_idle;

   assign added = jbt_pkg::word_add((mode_ff == jbt_pkg::MODE_WORD) ? word_ff
                                                                   : jbt_pkg::WORD_CLEAR,
                                    text_byte);

   always_comb begin
      mode_in   = mode_ff;
      word_in   = word_ff;
      main_emit = 1'b0;
      main_kind = jbt_pkg::KIND_TEXT;
      idle_emit = 1'b0;
      idle_kind = jbt_pkg::KIND_TEXT;
      eot_emit  = 1'b0;
      eot_kind  = jbt_pkg::KIND_OPEN_STRING;
      do_idle   = 1'b0;

      unique case (mode_ff)
         jbt_pkg::MODE_STRING: begin
            main_emit = 1'b1;
            if (text_byte == jbt_pkg::CHAR_QUOTE) begin
               main_kind = jbt_pkg::KIND_STRING;
               mode_in   = jbt_pkg::MODE_IDLE;
            end else begin
               main_kind = jbt_pkg::KIND_TEXT;
            end
         end
         jbt_pkg::MODE_WORD: begin
            main_emit = 1'b1;
            if (jbt_pkg::is_alnum(text_byte) || (text_byte == jbt_pkg::CHAR_DOT)) begin
               main_kind = jbt_pkg::KIND_TEXT;
               word_in   = added;
            end else begin
               main_kind = jbt_pkg::word_kind(word_ff);
               word_in   = jbt_pkg::WORD_CLEAR;
               mode_in   = jbt_pkg::MODE_IDLE;
               do_idle   = 1'b1;
            end
         end
         default: begin
            mode_in = jbt_pkg::MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         idle_emit = 1'b1;
         unique case (text_byte)
            jbt_pkg::CHAR_LBRACE:   idle_kind = jbt_pkg::KIND_LBRACE;
            jbt_pkg::CHAR_RBRACE:   idle_kind = jbt_pkg::KIND_RBRACE;
            jbt_pkg::CHAR_LBRACKET: idle_kind = jbt_pkg::KIND_LBRACKET;
            jbt_pkg::CHAR_RBRACKET: idle_kind = jbt_pkg::KIND_RBRACKET;
            jbt_pkg::CHAR_COLON:    idle_kind = jbt_pkg::KIND_COLON;
            jbt_pkg::CHAR_COMMA:    idle_kind = jbt_pkg::KIND_COMMA;
            jbt_pkg::CHAR_QUOTE: begin
               idle_emit = 1'b0;
               mode_in   = jbt_pkg::MODE_STRING;
            end
            default: begin
               if (jbt_pkg::is_alnum(text_byte)) begin
                  idle_kind = jbt_pkg::KIND_TEXT;
                  mode_in   = jbt_pkg::MODE_WORD;
                  word_in   = added;
               end else begin
                  idle_emit = 1'b0;
               end
            end
         endcase
      end

      if (end_of_text) begin
         if (mode_in == jbt_pkg::MODE_WORD) begin
            eot_emit = 1'b1;
            eot_kind = jbt_pkg::word_kind(word_in);
         end else if (mode_in == jbt_pkg::MODE_STRING) begin
            eot_emit = 1'b1;
            eot_kind = jbt_pkg::KIND_OPEN_STRING;
         end
         mode_in = jbt_pkg::MODE_IDLE;
         word_in = jbt_pkg::WORD_CLEAR;
      end
   end

   // pack the up to two emitted kinds into result slots, in order
   always_comb begin
      jbt_pkg::token_kind_type k0, k1;
      logic [1:0]              n;
      k0 = jbt_pkg::KIND_TEXT;
      k1 = jbt_pkg::KIND_TEXT;
      n  = 2'd0;
      priority if (main_emit) begin
         k0 = main_kind;
         n  = 2'd1;
         if (idle_emit) begin
            k1 = idle_kind;
            n  = 2'd2;
         end else if (eot_emit) begin
            k1 = eot_kind;
            n  = 2'd2;
         end
      end else if (idle_emit) begin
         k0 = idle_kind;
         n  = 2'd1;
         if (eot_emit) begin
            k1 = eot_kind;
            n  = 2'd2;
         end
      end else if (eot_emit) begin
         k0 = eot_kind;
         n  = 2'd1;
      end else begin
         n = 2'd0;
      end
      result.count               = n;
      result.items[0].kind       = k0;
      result.items[0].char_value = (k0 == jbt_pkg::KIND_TEXT) ? text_byte : 8'h00;
      result.items[0].run_end    = (n == 2'd1);
      result.items[1].kind       = k1;
      result.items[1].char_value = (k1 == jbt_pkg::KIND_TEXT) ? text_byte : 8'h00;
      result.items[1].run_end    = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jbt_pkg::MODE_IDLE;
         word_ff <= jbt_pkg::WORD_CLEAR;
      end else if (fire) begin
         mode_ff <= mode_in;
         word_ff <= word_in;
      end
   end

   a_eot_returns_idle: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_text |=> (mode_ff == jbt_pkg::MODE_IDLE) && (word_ff == jbt_pkg::WORD_CLEAR))
      else $error("scan state not cleared after end of text");

   a_open_string_last: assert property (@(posedge clock) disable iff (reset)
      fire && end_of_text && (mode_ff == jbt_pkg::MODE_STRING) &&
      (text_byte != jbt_pkg::CHAR_QUOTE)
      |-> (result.count == 2'd2) && (result.items[1].kind == jbt_pkg::KIND_OPEN_STRING))
      else $error("open string at end of text not reported");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fire |-> (result.count != 2'd3))
      else $error("more than two results for one byte");

endmodule

// ----- rtl/jbt_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// jbt_rsp_queue
// Four-entry result queue: takes up to two results a cycle from the scanner
// while it has room; drives the response channel one result a cycle on ready.
// ----------------------------------------------------------------------------
module jbt_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jbt_pkg::scan_out_type result,
   output logic                 has_room,
   jbt_rsp_if.source            rsp
);

   jbt_pkg::rsp_item_type entry_ff [4];
   logic [1:0]            wr_ptr_ff, wr_ptr_in;
   logic [1:0]            rd_ptr_ff, rd_ptr_in;
   logic [2:0]            count_ff, count_in;
   logic [1:0]            push_n;
   logic                  pop;
   logic [1:0]            wr_next;

   assign push_n    = push ? result.count : 2'd0;
   assign pop       = (count_ff != 3'd0) && rsp.ready;
   assign wr_next   = wr_ptr_ff + 2'd1;
   assign wr_ptr_in = wr_ptr_ff + push_n;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};
   // room for a worst-case two-result byte
   assign has_room  = (count_ff <= 3'd2);

   assign rsp.valid      = (count_ff != 3'd0);
   assign rsp.token_kind = entry_ff[rd_ptr_ff].kind;
   assign rsp.char_value = entry_ff[rd_ptr_ff].char_value;
   assign rsp.run_end    = entry_ff[rd_ptr_ff].run_end;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) entry_ff[wr_ptr_ff] <= result.items[0];
      if (push_n == 2'd2) entry_ff[wr_next]   <= result.items[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff <= 3'd2))
      else $error("push into a queue without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 3'd4) |-> ((wr_ptr_ff - rd_ptr_ff) == count_ff[1:0]))
      else $error("queue pointers disagree with count");

endmodule

// ----- rtl/json_byte_tokenizer.sv -----
// Path: a request waits in the input holding register until the queue has room. Throughput:
// one request per cycle while each byte gives at most one response and the response side
// is ready; a byte that gives two responses (word close plus punctuation, or a result plus
// end-of-text token) needs two transfers on the one response port, buffered by a 4-entry queue.
// Reset: synchronous; clears scan mode, word flags, input valid flag, queue pointers and count.
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON tokenizer top level: input holding register, scanner and
// result queue.
// ----------------------------------------------------------------------------
module json_byte_tokenizer (
   input  logic      clock,
   input  logic      reset,
   jbt_req_if.sink   req,
   jbt_rsp_if.source rsp
);

   logic                  in_valid_ff;
   logic [7:0]            byte_ff;
   logic                  eot_ff;
   logic                  has_room;
   logic                  go;
   jbt_pkg::scan_out_type result;

   assign go        = in_valid_ff && has_room;
   assign req.ready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff <= req.text_byte;
         eot_ff  <= req.end_of_text;
      end
   end

   jbt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .fire        (go),
      .text_byte   (byte_ff),
      .end_of_text (eot_ff),
      .result      (result)
   );

   jbt_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (go),
      .result   (result),
      .has_room (has_room),
      .rsp      (rsp)
   );

endmodule
